@@ rtl/core/particle_pool_update_core_macros.svh @@
// ----------------------------------------------------------------------------
// particle_pool_update_core_macros.svh
// Assertion macros used by the particle pool core.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_UPDATE_CORE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PUP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PUP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pup_pkg.sv @@
// ----------------------------------------------------------------------------
// pup_pkg
// Types, constants and helpers of the particle pool update core.
// ----------------------------------------------------------------------------
package pup_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = 6;

  // configuration register indexes
  localparam logic [2:0] CFG_GRAV_X    = 3'd0;
  localparam logic [2:0] CFG_GRAV_Y    = 3'd1;
  localparam logic [2:0] CFG_GRAV_Z    = 3'd2;
  localparam logic [2:0] CFG_SCALE_EN  = 3'd3;
  localparam logic [2:0] CFG_SCALE_BEG = 3'd4;
  localparam logic [2:0] CFG_FADE_EN   = 3'd5;
  localparam logic [2:0] CFG_FADE_BEG  = 3'd6;

  // one slot of the pool as held in memory
  typedef struct packed {
    logic [30:0]        init_life;
    logic [30:0]        rem_life;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        size;
    logic [15:0]        alpha;
  } pup_rec_t;

  // request to the divider
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [30:0] den;
  } pup_div_req_t;

  // signed add saturated to 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

@@ rtl/core/particle_pool_update_core.sv @@
// ----------------------------------------------------------------------------
// particle_pool_update_core
// Pool of 64 fixed-point particles: spawn into a free slot, tick to advance.
// ----------------------------------------------------------------------------
// A spawn word runs a free-slot search that steps one slot a cycle from the
// last used slot, then one memory write. A tick word emits 64 result words,
// one per slot. A live slot runs the six gravity and position multiplies on
// the shared multiplier, the life-fraction divide, and one more divide and
// multiply for each of size and alpha when its shrink is active; a dead slot
// skips them. The divider is serial (one bit a cycle) and shared, and the slot
// memory has one write port and one read port. Stalls on the result side hold
// the core in its emit state. Inputs are taken only between words.
// ----------------------------------------------------------------------------
`include "particle_pool_update_core_macros.svh"

module particle_pool_update_core
  import pup_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [30:0]        in_dt,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [30:0]        in_life,
  input  logic [30:0]        in_size_in,
  input  logic [15:0]        in_alpha_in,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_slot,
  output logic               out_alive,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [30:0]        out_size,
  output logic [15:0]        out_alpha,
  output logic               out_last
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SRCH  = 5'd1;
  localparam logic [4:0] ST_SPWR  = 5'd2;
  localparam logic [4:0] ST_RD    = 5'd3;
  localparam logic [4:0] ST_DAT   = 5'd4;
  localparam logic [4:0] ST_MUL   = 5'd5;
  localparam logic [4:0] ST_ACC   = 5'd6;
  localparam logic [4:0] ST_DIVF  = 5'd7;
  localparam logic [4:0] ST_SHCHK = 5'd8;
  localparam logic [4:0] ST_SHDIV = 5'd9;
  localparam logic [4:0] ST_SHMUL = 5'd10;
  localparam logic [4:0] ST_SHACC = 5'd11;
  localparam logic [4:0] ST_WB    = 5'd12;
  localparam logic [4:0] ST_EMIT  = 5'd13;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

  // configuration registers
  logic signed [31:0] grav_x_r, grav_y_r, grav_z_r;
  logic               scale_en_r, fade_en_r;
  logic [15:0]        scale_beg_r, fade_beg_r;

  // control state
  logic [4:0]           state_r, state_nxt;
  logic [MAX_SLOTS-1:0] live_r, live_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SLOT_W-1:0]    start_r, start_nxt;
  logic [SLOT_W:0]      scnt_r, scnt_nxt;
  logic [2:0]           mcnt_r, mcnt_nxt;
  logic                 shsel_r, shsel_nxt;
  logic                 spawn_r, spawn_nxt;
  logic                 alive_r, alive_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // datapath registers
  pup_rec_t    rec_r, rec_nxt;
  logic [30:0] dt_r, dt_nxt;
  logic [16:0] frac_r, frac_nxt;
  logic [16:0] fac_r, fac_nxt;

  // output registers
  logic [5:0]         o_slot_r;
  logic               o_alive_r, o_last_r;
  logic signed [31:0] o_x_r, o_y_r, o_z_r;
  logic [30:0]        o_size_r;
  logic [15:0]        o_alpha_r;

  // memory, divider and multiplier hookup
  pup_rec_t           ram_rdata;
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_raddr;
  pup_div_req_t       div_req;
  logic               div_done;
  logic [16:0]        div_quo;
  logic signed [31:0] mul_a, mul_b, mul_res;

  logic               in_acc, out_load;
  logic signed [31:0] rem_n;
  logic               sh_en;
  logic [15:0]        sh_beg;
  logic [16:0]        sh_diff;

  pup_ram #(.WIDTH($bits(pup_rec_t)), .DEPTH(MAX_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (rec_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pup_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  pup_qmul u_qmul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_x_r    <= '0;
      grav_y_r    <= '0;
      grav_z_r    <= '0;
      scale_en_r  <= 1'b0;
      scale_beg_r <= '0;
      fade_en_r   <= 1'b0;
      fade_beg_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GRAV_X:    grav_x_r    <= cfg_wdata;
        CFG_GRAV_Y:    grav_y_r    <= cfg_wdata;
        CFG_GRAV_Z:    grav_z_r    <= cfg_wdata;
        CFG_SCALE_EN:  scale_en_r  <= cfg_wdata[0];
        CFG_SCALE_BEG: scale_beg_r <= cfg_wdata[15:0];
        CFG_FADE_EN:   fade_en_r   <= cfg_wdata[0];
        CFG_FADE_BEG:  fade_beg_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // handshakes and shrink selection
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign ram_we   = (state_r == ST_SPWR) || (state_r == ST_WB);
  assign ram_raddr = slot_r;
  assign rem_n    = $signed({1'b0, ram_rdata.rem_life}) - $signed({1'b0, dt_r});
  assign sh_en    = shsel_r ? fade_en_r : scale_en_r;
  assign sh_beg   = shsel_r ? fade_beg_r : scale_beg_r;
  assign sh_diff  = frac_r - {1'b0, sh_beg};

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = $signed({1'b0, dt_r});
    if (state_r == ST_SHMUL) begin
      mul_a = shsel_r ? $signed({16'd0, rec_r.alpha}) : $signed({1'b0, rec_r.size});
      mul_b = $signed({15'd0, fac_r});
    end else begin
      unique case (mcnt_r)
        3'd0:    mul_a = grav_x_r;
        3'd1:    mul_a = grav_y_r;
        3'd2:    mul_a = grav_z_r;
        3'd3:    mul_a = rec_r.vel_x;
        3'd4:    mul_a = rec_r.vel_y;
        default: mul_a = rec_r.vel_z;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    live_nxt  = live_r;
    slot_nxt  = slot_r;
    start_nxt = start_r;
    scnt_nxt  = scnt_r;
    mcnt_nxt  = mcnt_r;
    shsel_nxt = shsel_r;
    spawn_nxt = spawn_r;
    alive_nxt = alive_r;
    rec_nxt   = rec_r;
    dt_nxt    = dt_r;
    frac_nxt  = frac_r;
    fac_nxt   = fac_r;
    div_req   = '{start: 1'b0, num: '0, den: '0};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          spawn_nxt = in_cmd;
          if (in_cmd) begin
            rec_nxt.init_life = in_life;
            rec_nxt.rem_life  = in_life;
            rec_nxt.pos_x     = in_pos_x;
            rec_nxt.pos_y     = in_pos_y;
            rec_nxt.pos_z     = in_pos_z;
            rec_nxt.vel_x     = in_vel_x;
            rec_nxt.vel_y     = in_vel_y;
            rec_nxt.vel_z     = in_vel_z;
            rec_nxt.size      = in_size_in;
            rec_nxt.alpha     = in_alpha_in;
            slot_nxt  = start_r;
            scnt_nxt  = '0;
            state_nxt = ST_SRCH;
          end else begin
            dt_nxt    = in_dt;
            slot_nxt  = '0;
            state_nxt = ST_RD;
          end
        end
      end
      // round-robin search for a dead slot, slot 0 when the pool is full
      ST_SRCH: begin
        if (!live_r[slot_r]) begin
          state_nxt = ST_SPWR;
        end else if (scnt_r == (SLOT_W + 1)'(MAX_SLOTS - 1)) begin
          slot_nxt  = '0;
          state_nxt = ST_SPWR;
        end else begin
          slot_nxt  = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
          scnt_nxt  = scnt_r + (SLOT_W + 1)'(1);
        end
      end
      ST_SPWR: begin
        live_nxt[slot_r] = (rec_r.rem_life != '0);
        alive_nxt        = (rec_r.rem_life != '0);
        start_nxt        = slot_r;
        state_nxt        = ST_EMIT;
      end
      ST_RD: begin
        state_nxt = ST_DAT;
      end
      // lifetime update and death check
      ST_DAT: begin
        rec_nxt = ram_rdata;
        if (!live_r[slot_r]) begin
          alive_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else if (rem_n[31] || (rem_n == '0)) begin
          rec_nxt.alpha    = '0;
          live_nxt[slot_r] = 1'b0;
          alive_nxt        = 1'b0;
          state_nxt        = ST_WB;
        end else begin
          rec_nxt.rem_life = rem_n[30:0];
          alive_nxt        = 1'b1;
          mcnt_nxt         = '0;
          state_nxt        = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      // velocity then position accumulate
      ST_ACC: begin
        unique case (mcnt_r)
          3'd0:    rec_nxt.vel_x = sat_add(rec_r.vel_x, mul_res);
          3'd1:    rec_nxt.vel_y = sat_add(rec_r.vel_y, mul_res);
          3'd2:    rec_nxt.vel_z = sat_add(rec_r.vel_z, mul_res);
          3'd3:    rec_nxt.pos_x = sat_add(rec_r.pos_x, mul_res);
          3'd4:    rec_nxt.pos_y = sat_add(rec_r.pos_y, mul_res);
          default: rec_nxt.pos_z = sat_add(rec_r.pos_z, mul_res);
        endcase
        if (mcnt_r == 3'd5) begin
          div_req.start = 1'b1;
          div_req.num   = {1'b0, rec_r.rem_life, 16'd0};
          div_req.den   = rec_r.init_life;
          state_nxt     = ST_DIVF;
        end else begin
          mcnt_nxt  = mcnt_r + 3'd1;
          state_nxt = ST_MUL;
        end
      end
      // life fraction from remaining over initial
      ST_DIVF: begin
        div_req.den = rec_r.init_life;
        if (div_done) begin
          frac_nxt  = 17'd65536 - div_quo;
          shsel_nxt = 1'b0;
          state_nxt = ST_SHCHK;
        end
      end
      // size pass, then alpha pass
      ST_SHCHK: begin
        if (sh_en && (frac_r >= {1'b0, sh_beg})) begin
          div_req.start = 1'b1;
          div_req.num   = {15'd0, sh_diff, 16'd0};
          div_req.den   = 31'(17'd65536 - {1'b0, sh_beg});
          state_nxt     = ST_SHDIV;
        end else if (!shsel_r) begin
          shsel_nxt = 1'b1;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_SHDIV: begin
        div_req.den = 31'(17'd65536 - {1'b0, sh_beg});
        if (div_done) begin
          fac_nxt   = 17'd65536 - div_quo;
          state_nxt = ST_SHMUL;
        end
      end
      ST_SHMUL: begin
        state_nxt = ST_SHACC;
      end
      ST_SHACC: begin
        if (shsel_r) begin
          rec_nxt.alpha = mul_res[15:0];
          state_nxt     = ST_WB;
        end else begin
          rec_nxt.size  = mul_res[30:0];
          shsel_nxt     = 1'b1;
          state_nxt     = ST_SHCHK;
        end
      end
      ST_WB: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          if (spawn_r || (slot_r == LAST_SLOT)) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt  = slot_r + SLOT_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      slot_r      <= '0;
      start_r     <= '0;
      scnt_r      <= '0;
      mcnt_r      <= '0;
      shsel_r     <= 1'b0;
      spawn_r     <= 1'b0;
      alive_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      slot_r      <= slot_nxt;
      start_r     <= start_nxt;
      scnt_r      <= scnt_nxt;
      mcnt_r      <= mcnt_nxt;
      shsel_r     <= shsel_nxt;
      spawn_r     <= spawn_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers; dead slots report zeros
  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    dt_r   <= dt_nxt;
    frac_r <= frac_nxt;
    fac_r  <= fac_nxt;
    if (out_load) begin
      o_slot_r  <= slot_r;
      o_alive_r <= alive_r;
      o_last_r  <= spawn_r || (slot_r == LAST_SLOT);
      o_x_r     <= alive_r ? rec_r.pos_x : '0;
      o_y_r     <= alive_r ? rec_r.pos_y : '0;
      o_z_r     <= alive_r ? rec_r.pos_z : '0;
      o_size_r  <= alive_r ? rec_r.size : '0;
      o_alpha_r <= alive_r ? rec_r.alpha : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot  = o_slot_r;
  assign out_alive = o_alive_r;
  assign out_x     = o_x_r;
  assign out_y     = o_y_r;
  assign out_z     = o_z_r;
  assign out_size  = o_size_r;
  assign out_alpha = o_alpha_r;
  assign out_last  = o_last_r;

  // checks
  `PUP_ASSERT_IMP(a_div_done_state, div_done, (state_r == ST_DIVF) || (state_r == ST_SHDIV), "divider finished outside a divide wait")
  `PUP_ASSERT_IMP(a_load_free, out_load, !out_valid_r || out_ready, "result overwritten before taken")
  `PUP_ASSERT_NXT(a_spawn_live, (state_r == ST_SPWR) && (rec_r.rem_life != '0), live_r[start_r], "spawned slot not marked live")

endmodule

@@ rtl/core/pup_ram.sv @@
// ----------------------------------------------------------------------------
// pup_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pup_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/pup_div.sv @@
// ----------------------------------------------------------------------------
// pup_div
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// The caller guarantees num < den * 2^17.
// ----------------------------------------------------------------------------
module pup_div
  import pup_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  pup_div_req_t req,
  output logic         done,
  output logic [16:0]  quo
);

  logic [31:0] rem_r, rem_nxt;
  logic [16:0] num_r, num_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] trial;
  logic        qbit;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r[30:0], num_r[16]};
    qbit     = (trial >= {1'b0, req.den});
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = {1'b0, req.num[47:17]};
      num_nxt  = req.num[16:0];
      quo_nxt  = '0;
      cnt_nxt  = 5'd17;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? (trial - {1'b0, req.den}) : trial;
      num_nxt = {num_r[15:0], 1'b0};
      quo_nxt = {quo_r[15:0], qbit};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ rtl/core/pup_qmul.sv @@
// ----------------------------------------------------------------------------
// pup_qmul
// Q16.16 multiply: floor(a*b/65536) saturated to 32 bits, registered.
// ----------------------------------------------------------------------------
module pup_qmul
  import pup_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] res
);

  logic signed [63:0] prod;
  logic signed [47:0] shr;
  logic signed [31:0] res_nxt;

  // arithmetic shift floors; saturate when the top bits disagree
  always_comb begin
    prod = a * b;
    shr  = prod[63:16];
    if (shr[47:31] != {17{shr[47]}}) begin
      res_nxt = shr[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res_nxt = shr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_nxt;
  end

endmodule

@@ tb/sv/particle_pool_update_core_test.sv @@
// ----------------------------------------------------------------------------
// particle_pool_update_core_test
// Self-checking bench for the particle pool core: a predictor of spawn and tick
// behavior, a queued driver and a monitor, run over several configurations and
// idle/stall mixes.
// ----------------------------------------------------------------------------
module particle_pool_update_core_test
  import pup_pkg::*;
;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SPAWN = 1'b1;
  localparam longint Q_ONE   = 65536;

  typedef struct {
    logic               cmd;
    logic [30:0]        dt;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic [30:0]        life;
    logic [30:0]        size;
    logic [15:0]        alpha;
  } particle_word_t;

  typedef struct {
    logic [5:0]  slot;
    logic        alive;
    logic [31:0] x, y, z;
    logic [30:0] size;
    logic [15:0] alpha;
    logic        last;
  } slot_report_t;

  // DUT signals
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_idx = CFG_GRAV_X;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_cmd = CMD_TICK;
  logic [30:0]        in_dt = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic [30:0]        in_life = '0, in_size_in = '0;
  logic [15:0]        in_alpha_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [5:0]         out_slot;
  logic               out_alive;
  logic signed [31:0] out_x, out_y, out_z;
  logic [30:0]        out_size;
  logic [15:0]        out_alpha;
  logic               out_last;

  particle_pool_update_core u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  longint      rem_life[MAX_SLOTS], init_life[MAX_SLOTS];
  longint      pos_x[MAX_SLOTS], pos_y[MAX_SLOTS], pos_z[MAX_SLOTS];
  longint      vel_x[MAX_SLOTS], vel_y[MAX_SLOTS], vel_z[MAX_SLOTS];
  longint      psize[MAX_SLOTS], palpha[MAX_SLOTS];
  int          search_ptr;
  longint      grav_x, grav_y, grav_z;
  longint      scale_en, scale_beg, fade_en, fade_beg;

  particle_word_t pending_words[$];
  particle_word_t cur_word;
  slot_report_t   expected_reports[$];
  int             sent_cnt = 0, taken_cnt = 0;
  int             send_idle_pct = 0, recv_stall_pct = 0;
  int             err_cnt = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product floored by the arithmetic shift, then saturated
  function automatic longint fx_mul(longint a, longint b);
    return sat32((a * b) >>> 16);
  endfunction

  function automatic longint shrink_value(longint value, longint frac, longint beg);
    longint t;
    if (frac < beg) return value;
    t = ((frac - beg) << 16) / (Q_ONE - beg);
    if (t > Q_ONE) t = Q_ONE;
    return (value * (Q_ONE - t)) >> 16;
  endfunction

  // append a word to the driver queue
  function automatic void queue_word(particle_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void push_report(int i, bit is_last);
    slot_report_t r;
    bit live;
    live    = rem_life[i] > 0;
    r.slot  = 6'(i);
    r.alive = live;
    r.x     = live ? 32'(pos_x[i]) : '0;
    r.y     = live ? 32'(pos_y[i]) : '0;
    r.z     = live ? 32'(pos_z[i]) : '0;
    r.size  = live ? 31'(psize[i]) : '0;
    r.alpha = live ? 16'(palpha[i]) : '0;
    r.last  = is_last;
    expected_reports = {expected_reports, r};
  endfunction

  // apply one accepted word to the pool model
  function automatic void predict_word(particle_word_t w);
    int pick;
    bit found;
    longint dt, q, frac;
    if (w.cmd == CMD_SPAWN) begin
      pick  = 0;
      found = 0;
      for (int k = 0; k < MAX_SLOTS && !found; k++) begin
        int i;
        i = (search_ptr + k) % MAX_SLOTS;
        if (rem_life[i] <= 0) begin
          pick  = i;
          found = 1;
        end
      end
      search_ptr      = pick;
      pos_x[pick]     = w.pos_x;
      pos_y[pick]     = w.pos_y;
      pos_z[pick]     = w.pos_z;
      vel_x[pick]     = w.vel_x;
      vel_y[pick]     = w.vel_y;
      vel_z[pick]     = w.vel_z;
      rem_life[pick]  = w.life;
      init_life[pick] = w.life;
      psize[pick]     = w.size;
      palpha[pick]    = w.alpha;
      push_report(pick, 1'b1);
    end else begin
      dt = w.dt;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (rem_life[i] > 0) begin
          rem_life[i] = sat32(rem_life[i] - dt);
          if (rem_life[i] > 0) begin
            vel_x[i] = sat32(vel_x[i] + fx_mul(grav_x, dt));
            vel_y[i] = sat32(vel_y[i] + fx_mul(grav_y, dt));
            vel_z[i] = sat32(vel_z[i] + fx_mul(grav_z, dt));
            pos_x[i] = sat32(pos_x[i] + fx_mul(vel_x[i], dt));
            pos_y[i] = sat32(pos_y[i] + fx_mul(vel_y[i], dt));
            pos_z[i] = sat32(pos_z[i] + fx_mul(vel_z[i], dt));
            if (init_life[i] <= 0) begin
              frac = Q_ONE;
            end else begin
              q = (rem_life[i] << 16) / init_life[i];
              if (q > Q_ONE) q = Q_ONE;
              frac = Q_ONE - q;
            end
            if (scale_en != 0) psize[i] = shrink_value(psize[i], frac, scale_beg) & 'h7FFFFFFF;
            if (fade_en != 0) palpha[i] = shrink_value(palpha[i], frac, fade_beg) & 'hFFFF;
          end else begin
            palpha[i] = 0;
          end
        end
        push_report(i, i == MAX_SLOTS - 1);
      end
    end
  endfunction

  // input acceptance feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_word(cur_word);
      taken_cnt <= taken_cnt + 1;
    end
  end

  // driver: one word in flight at a time, new words launched at the falling edge
  always @(negedge clk) begin
    if (rst_n && (sent_cnt == taken_cnt)) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_word     = pending_words.pop_front();
        in_cmd      <= cur_word.cmd;
        in_dt       <= cur_word.dt;
        in_pos_x    <= cur_word.pos_x;
        in_pos_y    <= cur_word.pos_y;
        in_pos_z    <= cur_word.pos_z;
        in_vel_x    <= cur_word.vel_x;
        in_vel_y    <= cur_word.vel_y;
        in_vel_z    <= cur_word.vel_z;
        in_life     <= cur_word.life;
        in_size_in  <= cur_word.size;
        in_alpha_in <= cur_word.alpha;
        in_valid    <= 1'b1;
        sent_cnt    <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // monitor: compare each result word with the oldest expected report
  always @(posedge clk) begin
    slot_report_t r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result word for slot %0d", out_slot);
        err_cnt++;
      end else begin
        r = expected_reports.pop_front();
        check_field("slot", r.slot, out_slot);
        check_field("alive", r.alive, out_alive);
        check_field("out_x", r.x, $unsigned(out_x));
        check_field("out_y", r.y, $unsigned(out_y));
        check_field("out_z", r.z, $unsigned(out_z));
        check_field("out_size", r.size, out_size);
        check_field("out_alpha", r.alpha, out_alpha);
        check_field("last", r.last, out_last);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GRAV_X:    grav_x = longint'(signed'(val));
      CFG_GRAV_Y:    grav_y = longint'(signed'(val));
      CFG_GRAV_Z:    grav_z = longint'(signed'(val));
      CFG_SCALE_EN:  scale_en = val[0];
      CFG_SCALE_BEG: scale_beg = val[15:0];
      CFG_FADE_EN:   fade_en = val[0];
      CFG_FADE_BEG:  fade_beg = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                            bit sen, logic [15:0] sbeg, bit fen, logic [15:0] fbeg);
    write_reg(CFG_GRAV_X, gx);
    write_reg(CFG_GRAV_Y, gy);
    write_reg(CFG_GRAV_Z, gz);
    write_reg(CFG_SCALE_EN, 32'(sen));
    write_reg(CFG_SCALE_BEG, 32'(sbeg));
    write_reg(CFG_FADE_EN, 32'(fen));
    write_reg(CFG_FADE_BEG, 32'(fbeg));
  endtask

  function automatic particle_word_t make_spawn(logic [30:0] life);
    particle_word_t w;
    w.cmd   = CMD_SPAWN;
    w.dt    = 31'($urandom);
    w.pos_x = $urandom;
    w.pos_y = $urandom;
    w.pos_z = $urandom;
    w.vel_x = $urandom;
    w.vel_y = $urandom;
    w.vel_z = $urandom;
    w.life  = life;
    w.size  = 31'($urandom);
    w.alpha = 16'($urandom);
    return w;
  endfunction

  function automatic particle_word_t make_tick(logic [30:0] dt);
    particle_word_t w;
    w      = make_spawn(31'($urandom));
    w.cmd  = CMD_TICK;
    w.dt   = dt;
    return w;
  endfunction

  function automatic logic [30:0] rand_life();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 65) return 31'($urandom_range(1, 'h40000));
    return 31'($urandom);
  endfunction

  function automatic logic [30:0] rand_dt();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 31'($urandom);
    if (pick < 15) return 31'($urandom_range(0, 3));
    return 31'($urandom_range(0, 'h8000));
  endfunction

  // wait until every word is taken and every report seen, then let it settle
  task automatic drain();
    @(negedge clk);
    while (pending_words.size() != 0 || sent_cnt != taken_cnt ||
           expected_reports.size() != 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // random bursts: a few spawns then a few ticks, repeated until n_words are queued
  task automatic random_bursts(int n_words);
    int cnt;
    cnt = 0;
    while (cnt < n_words) begin
      repeat ($urandom_range(1, 6)) begin
        queue_word(make_spawn(rand_life()));
        cnt++;
      end
      repeat ($urandom_range(1, 3)) begin
        queue_word(make_tick(rand_dt()));
        cnt++;
      end
    end
  endtask

  initial begin
    particle_word_t w;
    search_ptr = 0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      rem_life[i] = 0; init_life[i] = 0;
      pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
      vel_x[i] = 0; vel_y[i] = 0; vel_z[i] = 0;
      psize[i] = 0; palpha[i] = 0;
    end
    grav_x = 0; grav_y = 0; grav_z = 0;
    scale_en = 0; scale_beg = 0; fade_en = 0; fade_beg = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero life, death on tick, shrink at both ends
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1, 16'd0, 1'b1, 16'hFFFF);
    w = make_spawn(31'd1);
    w.pos_x = 32'sh7FFF_FFFF; w.pos_y = 32'sh8000_0000; w.pos_z = '0;
    w.vel_x = 32'sh7FFF_FFFF; w.vel_y = 32'sh8000_0000; w.vel_z = '0;
    w.size = 31'h7FFF_FFFF; w.alpha = 16'hFFFF;
    queue_word(w);
    w = make_spawn(31'h7FFF_FFFF);
    w.size = '0; w.alpha = '0;
    queue_word(w);
    queue_word(make_spawn(31'd0));
    queue_word(make_spawn(31'h0002_0000));
    queue_word(make_spawn(31'h0000_8000));
    queue_word(make_tick(31'd0));
    queue_word(make_tick(31'd1));
    queue_word(make_tick(31'h0000_4000));
    queue_word(make_tick(31'h0000_4000));
    queue_word(make_tick(31'h0001_0000));
    queue_word(make_spawn(31'h7FFF_FFFF));
    queue_word(make_tick(31'h7FFF_FFFF));
    drain();

    // phase: no idling, random config
    send_idle_pct = 0; recv_stall_pct = 0;
    set_config($urandom, $urandom, $urandom, 1'b1, 16'($urandom), 1'b1, 16'($urandom));
    random_bursts(15);
    drain();

    // phase: sender idle, pool filled until slot 0 is overwritten
    send_idle_pct = 76; recv_stall_pct = 0;
    set_config(32'h7FFF_FFFF, 32'h8000_0000, $urandom, 1'b0, 16'hFFFF, 1'b1, 16'd0);
    repeat (MAX_SLOTS + 2) queue_word(make_spawn(31'h7FFF_0000));
    queue_word(make_tick(31'h0000_0100));
    queue_word(make_spawn(31'h0001_0000));
    queue_word(make_tick(31'h7FFF_FFFF));
    drain();

    // phase: receiver stalling
    send_idle_pct = 0; recv_stall_pct = 76;
    set_config($urandom, $urandom, $urandom, 1'b1, 16'h8000, 1'b0, 16'($urandom));
    random_bursts(20);
    drain();

    // phase: both sides idle
    send_idle_pct = 27; recv_stall_pct = 27;
    set_config(32'(-$urandom_range(0, 'h40000)), $urandom, 32'h0, 1'b1,
               16'($urandom), 1'b1, 16'($urandom));
    random_bursts(20);
    drain();

    if (expected_reports.size() != 0) begin
      $error("%0d expected results never arrived", expected_reports.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
